@@ sv/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants and the sequencer state type for the modular
// exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // Default operand width inside the datapath.
   localparam int unsigned DEFAULT_WIDTH = 32;

   // Width of the operand and result fields on the ports.
   localparam int unsigned FIELD_WIDTH = 32;

   // Sequencer states, one-hot coded.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_SQUARE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

@@ sv/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Computes base ** exponent mod modulus by right-to-left square and multiply,
// with every modular product formed bit-serially on one shared step unit.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries a base, an exponent and a modulus,
// and yields exactly one transfer on the rsp_ channel. A zero modulus returns
// a result of 0 with rsp_modulus_error set; a zero exponent returns 1 (not
// reduced). Otherwise the unit first reduces the base, then for every
// exponent bit up to the highest set one it multiplies the result by the
// running base when the bit is set and squares the base when higher set bits
// remain; each of these modular products is formed in the shared
// double/add/reduce unit, which handles one multiplier bit per cycle. The
// unit takes one item at a time; req_ready is high only while it is idle,
// and a finished result waits in the output register until it is taken.
module modular_exponentiation_unit #(
   parameter int unsigned WIDTH = modexp_pkg::DEFAULT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0] req_base_value,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0] req_exponent_value,
   input  logic [modexp_pkg::FIELD_WIDTH-1:0] req_modulus_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [modexp_pkg::FIELD_WIDTH-1:0] rsp_power_result,
   output logic                               rsp_modulus_error
);

   localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   // Sequencer and datapath registers.
   modexp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] scan_ff, scan_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] pow_ff, pow_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic             err_ff, err_in;

   // Output register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [modexp_pkg::FIELD_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic                               rsp_error_ff, rsp_error_in;

   // Operands cut to the datapath width.
   logic [WIDTH-1:0] in_base, in_exp, in_mod;

   // Shared step unit signals.
   logic [WIDTH-1:0] mcand;
   logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;
   logic [WIDTH:0]   mod_ext;
   logic [WIDTH-1:0] step_out;
   logic             req_xfer, out_free;

   assign in_base  = WIDTH'(req_base_value);
   assign in_exp   = WIDTH'(req_exponent_value);
   assign in_mod   = WIDTH'(req_modulus_value);
   assign req_ready = (state_ff == modexp_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Multiplicand selection: the result during a multiply, the base during a
   // square, and one while the base is being reduced.
   always_comb begin
      unique case (state_ff)
         modexp_pkg::ST_MULT:   mcand = pow_ff;
         modexp_pkg::ST_SQUARE: mcand = base_ff;
         default:               mcand = WIDTH'(1);
      endcase
   end

   // One step of MSB-first interleaved modular multiplication:
   // acc = (2 * acc + bit * mcand) mod m, with two conditional subtractions.
   always_comb begin
      mod_ext = {1'b0, mod_ff};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = dbl_red + (scan_ff[WIDTH-1] ? {1'b0, mcand} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
      step_out = sum_red[WIDTH-1:0];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      scan_in       = scan_ff;
      base_in       = base_ff;
      pow_in        = pow_ff;
      exp_in        = exp_ff;
      mod_in        = mod_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;

      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mod_in  = in_mod;
               exp_in  = in_exp;
               acc_in  = '0;
               scan_in = in_base;
               cnt_in  = CNT_LAST;
               err_in  = 1'b0;
               pow_in  = WIDTH'(1);
               priority if (in_mod == '0) begin
                  pow_in   = '0;
                  err_in   = 1'b1;
                  state_in = modexp_pkg::ST_DONE;
               end else if (in_exp == '0) begin
                  state_in = modexp_pkg::ST_DONE;
               end else begin
                  state_in = modexp_pkg::ST_REDUCE;
               end
            end
         end

         modexp_pkg::ST_REDUCE, modexp_pkg::ST_MULT, modexp_pkg::ST_SQUARE: begin
            acc_in  = step_out;
            scan_in = {scan_ff[WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               // Product finished: store it and pick the next operation.
               acc_in = '0;
               cnt_in = CNT_LAST;
               priority if (state_ff == modexp_pkg::ST_REDUCE) begin
                  base_in  = step_out;
                  scan_in  = step_out;
                  state_in = exp_ff[0] ? modexp_pkg::ST_MULT : modexp_pkg::ST_SQUARE;
               end else if (state_ff == modexp_pkg::ST_MULT) begin
                  pow_in   = step_out;
                  scan_in  = base_ff;
                  state_in = (exp_ff[WIDTH-1:1] == '0) ? modexp_pkg::ST_DONE
                                                       : modexp_pkg::ST_SQUARE;
               end else begin
                  // Square done: move to the next exponent bit.
                  base_in  = step_out;
                  scan_in  = step_out;
                  exp_in   = {1'b0, exp_ff[WIDTH-1:1]};
                  state_in = exp_ff[1] ? modexp_pkg::ST_MULT : modexp_pkg::ST_SQUARE;
               end
            end
         end

         modexp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = modexp_pkg::FIELD_WIDTH'(pow_ff);
               rsp_error_in  = err_ff;
               state_in      = modexp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      scan_ff       <= scan_in;
      base_ff       <= base_in;
      pow_ff        <= pow_in;
      exp_ff        <= exp_in;
      mod_ff        <= mod_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_power_result  = rsp_result_ff;
   assign rsp_modulus_error = rsp_error_ff;

endmodule

@@ bench/modular_exponentiation_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Sends base, exponent and modulus triples through the request channel and
// checks every response against a predictor of base ** exponent mod modulus.
// It covers directed corner cases, random operands with short and full
// exponents, random idling on both channels, and a long response stall.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_tb;

   localparam int unsigned STALL_LIMIT = 20000;
   localparam int unsigned HOLD_CYCLES = 3000;
   localparam int unsigned DRAIN_CYCLES = 2100;
   localparam int unsigned REPORT_LIMIT = 10;

   // One predicted response.
   typedef struct packed {
      logic [modexp_pkg::FIELD_WIDTH-1:0] power;
      logic                               modulus_error;
   } power_result_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [modexp_pkg::FIELD_WIDTH-1:0] req_base_value;
   logic [modexp_pkg::FIELD_WIDTH-1:0] req_exponent_value;
   logic [modexp_pkg::FIELD_WIDTH-1:0] req_modulus_value;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [modexp_pkg::FIELD_WIDTH-1:0] rsp_power_result;
   logic                               rsp_modulus_error;

   power_result_type pending_powers[$];
   int unsigned      mismatch_count = 0;
   int unsigned      quiet_cycles = 0;
   bit               send_idle_on = 1'b1;
   bit               recv_idle_on = 1'b1;
   bit               rsp_hold = 1'b0;

   modular_exponentiation_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_base_value     (req_base_value),
      .req_exponent_value (req_exponent_value),
      .req_modulus_value  (req_modulus_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_power_result   (rsp_power_result),
      .rsp_modulus_error  (rsp_modulus_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Square and multiply from the low exponent bit; products fit in 64 bits.
   function automatic power_result_type predict_power(
      input logic [modexp_pkg::FIELD_WIDTH-1:0] base,
      input logic [modexp_pkg::FIELD_WIDTH-1:0] exponent,
      input logic [modexp_pkg::FIELD_WIDTH-1:0] modulus);
      power_result_type                   res;
      logic [63:0]                        acc;
      logic [63:0]                        running;
      logic [63:0]                        modw;
      logic [modexp_pkg::FIELD_WIDTH-1:0] bits;
      res.power = '0;
      res.modulus_error = 1'b0;
      if (modulus == 0) begin
         res.modulus_error = 1'b1;
         return res;
      end
      // A zero exponent leaves the result at one, even for a modulus of one.
      acc = 64'd1;
      modw = {32'd0, modulus};
      if (exponent != 0) begin
         running = {32'd0, base} % modw;
         bits = exponent;
         while (bits != 0) begin
            if (bits[0])
               acc = (acc * running) % modw;
            running = (running * running) % modw;
            bits = bits >> 1;
         end
      end
      res.power = acc[modexp_pkg::FIELD_WIDTH-1:0];
      return res;
   endfunction

   // Operand values weighted toward the edges of the range.
   function automatic logic [modexp_pkg::FIELD_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom_range(1, 16);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 16);
         default: return $urandom();
      endcase
   endfunction

   // Offer one request and wait for its transfer; the expectation is queued
   // at the accepting edge.
   task automatic send_request(input logic [modexp_pkg::FIELD_WIDTH-1:0] base,
                               input logic [modexp_pkg::FIELD_WIDTH-1:0] exponent,
                               input logic [modexp_pkg::FIELD_WIDTH-1:0] modulus);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_base_value     <= base;
      req_exponent_value <= exponent;
      req_modulus_value  <= modulus;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_powers.push_back(predict_power(base, exponent, modulus));
   endtask

   // Random request; the exponent is cut to exp_bits low bits.
   task automatic send_random(input int unsigned exp_bits);
      logic [modexp_pkg::FIELD_WIDTH-1:0] exponent;
      exponent = pick_operand();
      if (exp_bits < modexp_pkg::FIELD_WIDTH)
         exponent = exponent & ((32'd1 << exp_bits) - 1);
      send_request(pick_operand(), exponent, pick_operand());
   endtask

   task automatic test_special_cases();
      // Zero exponent: one, unreduced, for any nonzero modulus.
      send_request(32'd0, 32'd0, 32'd5);
      send_request(32'd5, 32'd0, 32'd1);
      send_request(32'hFFFF_FFFF, 32'd0, 32'd7);
      // Zero modulus: error flag and a zero result, zero exponent included.
      send_request(32'd0, 32'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_request(32'd3, 32'd0, 32'd0);
      // A modulus of one with a nonzero exponent gives zero.
      send_request(32'd9, 32'd1, 32'd1);
      // Base not below the modulus, and a zero base.
      send_request(32'd100, 32'd3, 32'd7);
      send_request(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF);
      send_request(32'd0, 32'd5, 32'd7);
      // Full-width operands and the top exponent bit alone.
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      send_request(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
      send_request(32'd2, 32'd31, 32'hFFFF_FFFF);
      send_request(32'h8000_0000, 32'd1, 32'h8000_0001);
      send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
   endtask

   task automatic test_short_exponents();
      repeat (110) send_random($urandom_range(1, 8));
   endtask

   task automatic test_full_exponents();
      repeat (75) send_random(modexp_pkg::FIELD_WIDTH);
   endtask

   // Hold the response side off while requests keep coming, so the unit
   // fills up and stalls its input.
   task automatic test_input_stall();
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (6) send_random($urandom_range(1, 6));
      join
   endtask

   task automatic test_back_to_back();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      repeat (40) send_random($urandom_range(0, 10));
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   task automatic test_mixed_idling();
      repeat (40) begin
         send_idle_on = ($urandom_range(0, 1) == 1);
         recv_idle_on = ($urandom_range(0, 1) == 1);
         send_random(($urandom_range(0, 3) == 0) ? modexp_pkg::FIELD_WIDTH
                                                 : $urandom_range(0, 12));
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // Main sequence.
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_base_value     = '0;
      req_exponent_value = '0;
      req_modulus_value  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_short_exponents();
      test_full_exponents();
      test_input_stall();
      test_back_to_back();
      test_mixed_idling();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_powers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Response side: a random stall after each transfer, plus the long hold.
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            stall = recv_idle_on ? $urandom_range(0, 13) : 0;
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !rsp_hold && !reset;
         end
      end
   end

   // Compare every response transfer with the oldest expectation.
   always @(posedge clock) begin
      power_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_powers.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected response: power %h error %b",
                        rsp_power_result, rsp_modulus_error);
            mismatch_count++;
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power_result !== want.power ||
                rsp_modulus_error !== want.modulus_error) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("mismatch: power %h error %b, expected power %h error %b",
                           rsp_power_result, rsp_modulus_error,
                           want.power, want.modulus_error);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
